/* rtl/echoing_line_editor_command_match_unit_defines.svh */
// assertion macros for the line editor block
`ifndef ECHOING_LINE_EDITOR_COMMAND_MATCH_UNIT_DEFINES_SVH
`define ECHOING_LINE_EDITOR_COMMAND_MATCH_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ELCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ELCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/elcm_pkg.sv */
// shared constants, types and command text for the line editor
`timescale 1ns / 1ps

package elcm_pkg;

    localparam int LINE_MAX_DEF = 64;
    localparam int CMD_COUNT    = 4;
    localparam int CMD_MAX_LEN  = 18;
    localparam int CMD_TEXT_W   = 8 * CMD_MAX_LEN;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [2:0] CODE_UNKNOWN = 3'd0;
    localparam logic [2:0] CODE_HELP    = 3'd1;
    localparam logic [2:0] CODE_STATUS  = 3'd2;
    localparam logic [2:0] CODE_LED_ON  = 3'd3;
    localparam logic [2:0] CODE_LED_OFF = 3'd4;

    localparam logic [4:0] CMD_LEN [CMD_COUNT] = '{5'd4, 5'd6, 5'd17, 5'd18};

    localparam logic [CMD_TEXT_W-1:0] CMD_TEXT [CMD_COUNT] = '{
        {"Help", {(CMD_MAX_LEN - 4){8'h00}}},
        {"Status", {(CMD_MAX_LEN - 6){8'h00}}},
        {"LED Blue Light ON", {(CMD_MAX_LEN - 17){8'h00}}},
        "LED Blue Light OFF"
    };

    typedef enum logic [1:0] {
        RUN_CHAR = 2'd0,
        RUN_BS   = 2'd1,
        RUN_EOL  = 2'd2
    } run_t;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_FETCH   = 5'b00010,
        S_CMP     = 5'b00100,
        S_RESOLVE = 5'b01000,
        S_EMIT    = 5'b10000
    } state_t;

    // character i of command c, zero past the end of the text
    function automatic logic [7:0] cmd_char(input logic [1:0] c, input logic [4:0] i);
        logic [7:0] ch;
        ch = 8'h00;
        if (i < 5'(CMD_MAX_LEN))
        begin
            ch = CMD_TEXT[c][CMD_TEXT_W - 1 - 8 * i -: 8];
        end
        return ch;
    endfunction

endpackage

/* rtl/elcm_line_ram.sv */
// line store memory, one write port and one registered read port
`timescale 1ns / 1ps

module elcm_line_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/echoing_line_editor_command_match_unit.sv */
// Terminal line editor: stores and echoes received bytes, handles backspace, and on a
// carriage return or line feed echoes 0D 0A and reports which fixed command the line holds.
// One item is taken at a time. An ordinary byte yields one result and a backspace three, none
// for a byte on a full line or a backspace on an empty one; they follow one per cycle while
// out_ready is high. A line end walks the stored line through a single compare unit, each
// character in two steps, a memory read and then a compare against all commands, before
// the outcome is resolved and its results are emitted.
`timescale 1ns / 1ps
`include "echoing_line_editor_command_match_unit_defines.svh"

module echoing_line_editor_command_match_unit #(
    parameter int LINE_MAX = elcm_pkg::LINE_MAX_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       out_kind,
    output logic [7:0] out_byte,
    output logic [2:0] command_code,
    output logic       led_level,
    output logic       last_of_run
);

    import elcm_pkg::*;

    localparam int LEN_W = $clog2(LINE_MAX);

    state_t               state_reg, state_next;
    run_t                 run_reg, run_next;
    logic [1:0]           step_reg, step_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [LEN_W-1:0]     idx_reg, idx_next;
    logic [CMD_COUNT-1:0] match_reg, match_next;
    logic [2:0]           code_reg, code_next;
    logic                 led_reg, led_next;
    logic [7:0]           byte_reg, byte_next;

    logic       in_fire;
    logic       out_fire;
    logic       is_eol;
    logic       is_bs;
    logic       ram_we;
    logic [7:0] ram_rdata;
    logic       run_last;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign is_eol   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    assign is_bs    = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
    assign ram_we   = in_fire && !is_eol && !is_bs && (len_reg < LEN_W'(LINE_MAX - 1));

    elcm_line_ram #(
        .DEPTH (LINE_MAX),
        .ADDR_W(LEN_W)
    ) u_line_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(len_reg),
        .wdata(rx_byte),
        .raddr(idx_reg),
        .rdata(ram_rdata)
    );

    assign run_last = (run_reg == RUN_CHAR) || (step_reg == 2'd2);

    always_comb
    begin
        state_next = state_reg;
        run_next   = run_reg;
        step_next  = step_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        match_next = match_reg;
        code_next  = code_reg;
        led_next   = led_reg;
        byte_next  = byte_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    byte_next = rx_byte;
                    step_next = 2'd0;
                    idx_next  = '0;
                    if (is_eol)
                    begin
                        run_next = RUN_EOL;
                        for (int c = 0; c < CMD_COUNT; c++)
                        begin
                            match_next[c] = (len_reg == LEN_W'(CMD_LEN[c]));
                        end
                        state_next = (len_reg != '0) ? S_FETCH : S_RESOLVE;
                    end
                    else if (is_bs)
                    begin
                        if (len_reg != '0)
                        begin
                            run_next   = RUN_BS;
                            len_next   = len_reg - 1'b1;
                            state_next = S_EMIT;
                        end
                    end
                    else if (ram_we)
                    begin
                        run_next   = RUN_CHAR;
                        len_next   = len_reg + 1'b1;
                        state_next = S_EMIT;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                for (int c = 0; c < CMD_COUNT; c++)
                begin
                    match_next[c] = match_reg[c] &&
                        (ram_rdata == cmd_char(2'(c), idx_reg[4:0]));
                end
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg == len_reg - 1'b1) ? S_RESOLVE : S_FETCH;
            end
            S_RESOLVE:
            begin
                if (match_reg[0])
                begin
                    code_next = CODE_HELP;
                end
                else if (match_reg[1])
                begin
                    code_next = CODE_STATUS;
                end
                else if (match_reg[2])
                begin
                    code_next = CODE_LED_ON;
                    led_next  = 1'b1;
                end
                else if (match_reg[3])
                begin
                    code_next = CODE_LED_OFF;
                    led_next  = 1'b0;
                end
                else
                begin
                    code_next = CODE_UNKNOWN;
                end
                len_next   = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_fire)
                begin
                    step_next = step_reg + 1'b1;
                    if (run_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            run_reg   <= RUN_CHAR;
            step_reg  <= 2'd0;
            len_reg   <= '0;
            idx_reg   <= '0;
            match_reg <= '0;
            code_reg  <= CODE_UNKNOWN;
            led_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= run_next;
            step_reg  <= step_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            match_reg <= match_next;
            code_reg  <= code_next;
            led_reg   <= led_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    always_comb
    begin
        out_kind     = 1'b0;
        out_byte     = 8'h00;
        command_code = CODE_UNKNOWN;
        case (run_reg)
            RUN_CHAR:
            begin
                out_byte = byte_reg;
            end
            RUN_BS:
            begin
                out_byte = (step_reg == 2'd1) ? CH_SPACE : CH_BS;
            end
            RUN_EOL:
            begin
                if (step_reg == 2'd0)
                begin
                    out_byte = CH_CR;
                end
                else if (step_reg == 2'd1)
                begin
                    out_byte = CH_LF;
                end
                else
                begin
                    out_kind     = 1'b1;
                    command_code = code_reg;
                end
            end
            default:
            begin
                out_byte = 8'h00;
            end
        endcase
    end

    assign out_valid   = (state_reg == S_EMIT);
    assign led_level   = led_reg;
    assign last_of_run = run_last;

    `ELCM_ASSERT_NOW(a_len_bound, 1'b1, len_reg <= LEN_W'(LINE_MAX - 1), "line length overflow")
    `ELCM_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "input taken while result pending")
    `ELCM_ASSERT_NEXT(a_eol_clears, in_fire && is_eol, len_reg == '0 || state_reg != S_EMIT,
        "line end left length")
    `ELCM_ASSERT_NEXT(a_last_idle, out_fire && last_of_run, state_reg == S_IDLE,
        "run did not end on last item")
    `ELCM_ASSERT_NOW(a_outcome_last, out_valid && out_kind, last_of_run,
        "outcome not last of run")

endmodule

/* tb/echoing_line_editor_command_match_unit_test.sv */
// self-checking testbench for the terminal line editor with command matching
`timescale 1ns / 1ps

module echoing_line_editor_command_match_unit_test;

    import elcm_pkg::*;

    localparam int LINE_MAX = LINE_MAX_DEF;
    localparam int RANDOM_ITEMS = 280;
    localparam int SETTLE_CYCLES = 2 * LINE_MAX + 40;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic [2:0] code;
        logic       led;
        logic       last;
    } term_out_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        logic [2:0] code;
        logic       led;
    } script_row_t;

    localparam logic [2:0] CMD_CODE [4] = '{CODE_HELP, CODE_STATUS, CODE_LED_ON, CODE_LED_OFF};

    string cmd_text [4] = '{"Help", "Status", "LED Blue Light ON", "LED Blue Light OFF"};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       out_kind;
    logic [7:0] out_byte;
    logic [2:0] command_code;
    logic       led_level;
    logic       last_of_run;

    // typed expectation riding along with the current item
    logic       row_typed = 1'b0;
    logic [2:0] row_code = CODE_UNKNOWN;
    logic       row_led = 1'b0;

    // predicted editor state
    logic [7:0] line_buf [LINE_MAX];
    int         line_len = 0;
    logic       led_on = 1'b0;

    term_out_t  terminal_out_q [$];
    int         echoing_items = 0;
    int         mismatch_count = 0;
    bit         steady = 1'b0;

    echoing_line_editor_command_match_unit #(
        .LINE_MAX(LINE_MAX)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_kind(out_kind),
        .out_byte(out_byte),
        .command_code(command_code),
        .led_level(led_level),
        .last_of_run(last_of_run)
    );

    always #5 clk = ~clk;

    function automatic int predict_edit(input logic [7:0] b, output term_out_t r [3]);
        logic [2:0] code;
        bit same;
        code = CODE_UNKNOWN;
        if (b == CH_CR || b == CH_LF)
        begin
            for (int c = 0; c < 4 && code == CODE_UNKNOWN; c++)
            begin
                same = (line_len == cmd_text[c].len());
                for (int i = 0; same && i < line_len; i++)
                begin
                    if (line_buf[i] != cmd_text[c][i])
                    begin
                        same = 1'b0;
                    end
                end
                if (same)
                begin
                    code = CMD_CODE[c];
                end
            end
            if (code == CODE_LED_ON)
            begin
                led_on = 1'b1;
            end
            else if (code == CODE_LED_OFF)
            begin
                led_on = 1'b0;
            end
            line_len = 0;
            r[0] = '{1'b0, CH_CR, CODE_UNKNOWN, led_on, 1'b0};
            r[1] = '{1'b0, CH_LF, CODE_UNKNOWN, led_on, 1'b0};
            r[2] = '{1'b1, 8'h00, code, led_on, 1'b1};
            return 3;
        end
        if (b == CH_BS || b == CH_DEL)
        begin
            if (line_len == 0)
            begin
                return 0;
            end
            line_len--;
            r[0] = '{1'b0, CH_BS, CODE_UNKNOWN, led_on, 1'b0};
            r[1] = '{1'b0, CH_SPACE, CODE_UNKNOWN, led_on, 1'b0};
            r[2] = '{1'b0, CH_BS, CODE_UNKNOWN, led_on, 1'b1};
            return 3;
        end
        if (line_len < LINE_MAX - 1)
        begin
            line_buf[line_len] = b;
            line_len++;
            r[0] = '{1'b0, b, CODE_UNKNOWN, led_on, 1'b1};
            return 1;
        end
        return 0;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // item and result monitor
    always @(posedge clk)
    begin : monitor
        term_out_t r [3];
        term_out_t want;
        int n;
        if (rst_n && in_valid && in_ready)
        begin
            n = predict_edit(rx_byte, r);
            if (row_typed)
            begin
                n = 0;
                if (rx_byte == CH_CR || rx_byte == CH_LF)
                begin
                    r[0] = '{1'b0, CH_CR, CODE_UNKNOWN, row_led, 1'b0};
                    r[1] = '{1'b0, CH_LF, CODE_UNKNOWN, row_led, 1'b0};
                    r[2] = '{1'b1, 8'h00, row_code, row_led, 1'b1};
                    n = 3;
                end
            end
            for (int k = 0; k < n; k++)
            begin
                terminal_out_q.push_back(r[k]);
            end
            if (n > 0)
            begin
                echoing_items++;
            end
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (terminal_out_q.size() == 0)
            begin
                $error("unexpected result: kind %0h byte %0h code %0h",
                       out_kind, out_byte, command_code);
                mismatch_count++;
            end
            else
            begin
                want = terminal_out_q.pop_front();
                compare_field("out_kind", want.kind, out_kind);
                compare_field("out_byte", want.ch, out_byte);
                compare_field("command_code", want.code, command_code);
                compare_field("led_level", want.led, led_level);
                compare_field("last_of_run", want.last, last_of_run);
            end
        end
    end

    always @(posedge clk)
    begin
        out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 37);
    end

    task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                             input logic [2:0] code = CODE_UNKNOWN, input logic led = 1'b0);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(99) < 37)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        row_typed <= typed;
        row_code <= code;
        row_led <= led;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain_output();
        in_valid <= 1'b0;
        do @(posedge clk); while (terminal_out_q.size() != 0);
    endtask

    task automatic send_line_end();
        send_byte($urandom_range(1) ? CH_CR : CH_LF);
    endtask

    task automatic send_command_line();
        int c;
        int flip;
        logic [7:0] ch;
        c = $urandom_range(3);
        flip = ($urandom_range(99) < 15) ? $urandom_range(cmd_text[c].len() - 1) : -1;
        if ($urandom_range(99) < 10)
        begin
            send_byte($urandom_range(1) ? CH_BS : CH_DEL);
        end
        for (int i = 0; i < cmd_text[c].len(); i++)
        begin
            if ($urandom_range(99) < 10)
            begin
                send_byte(8'($urandom_range(8'h21, 8'h7E)));
                send_byte($urandom_range(1) ? CH_BS : CH_DEL);
            end
            ch = cmd_text[c][i];
            if (i == flip)
            begin
                ch = ch ^ (8'h01 << $urandom_range(7));
            end
            send_byte(ch);
        end
        send_line_end();
    endtask

    task automatic send_full_line();
        int n;
        n = $urandom_range(LINE_MAX - 2, LINE_MAX + 6);
        repeat (n) send_byte(8'($urandom_range(8'h20, 8'h7E)));
        repeat ($urandom_range(2)) send_byte($urandom_range(1) ? CH_BS : CH_DEL);
        repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)));
        send_line_end();
    endtask

    script_row_t opening_script [24] = '{
        '{CH_BS, 1'b1, CODE_UNKNOWN, 1'b0},
        '{CH_DEL, 1'b1, CODE_UNKNOWN, 1'b0},
        '{CH_CR, 1'b1, CODE_UNKNOWN, 1'b0},
        '{CH_LF, 1'b1, CODE_UNKNOWN, 1'b0},
        '{8'h00, 1'b0, CODE_UNKNOWN, 1'b0},
        '{8'hFF, 1'b0, CODE_UNKNOWN, 1'b0},
        '{CH_DEL, 1'b0, CODE_UNKNOWN, 1'b0},
        '{CH_BS, 1'b0, CODE_UNKNOWN, 1'b0},
        '{CH_BS, 1'b1, CODE_UNKNOWN, 1'b0},
        '{8'h00, 1'b0, CODE_UNKNOWN, 1'b0},
        '{CH_CR, 1'b1, CODE_UNKNOWN, 1'b0},
        '{"H", 1'b0, CODE_UNKNOWN, 1'b0},
        '{"e", 1'b0, CODE_UNKNOWN, 1'b0},
        '{"l", 1'b0, CODE_UNKNOWN, 1'b0},
        '{"p", 1'b0, CODE_UNKNOWN, 1'b0},
        '{"x", 1'b0, CODE_UNKNOWN, 1'b0},
        '{CH_DEL, 1'b0, CODE_UNKNOWN, 1'b0},
        '{CH_CR, 1'b1, CODE_HELP, 1'b0},
        '{"H", 1'b0, CODE_UNKNOWN, 1'b0},
        '{"e", 1'b0, CODE_UNKNOWN, 1'b0},
        '{"l", 1'b0, CODE_UNKNOWN, 1'b0},
        '{"p", 1'b0, CODE_UNKNOWN, 1'b0},
        '{"p", 1'b0, CODE_UNKNOWN, 1'b0},
        '{CH_LF, 1'b1, CODE_UNKNOWN, 1'b0}
    };

    initial
    begin
        int start;
        int pick;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_script[k])
        begin
            send_byte(opening_script[k].ch, opening_script[k].typed,
                      opening_script[k].code, opening_script[k].led);
        end
        drain_output();

        start = echoing_items;
        send_full_line();
        while (echoing_items - start < RANDOM_ITEMS)
        begin
            steady = (echoing_items - start >= 100) && (echoing_items - start < 170);
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                send_command_line();
            end
            else if (pick < 70)
            begin
                repeat ($urandom_range(8)) send_byte(8'($urandom_range(255)));
                send_line_end();
            end
            else if (pick < 75)
            begin
                send_full_line();
            end
            else if (pick < 95)
            begin
                send_byte(8'($urandom_range(255)));
            end
            else
            begin
                drain_output();
            end
        end
        steady = 1'b0;

        drain_output();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("** echoing_line_editor_command_match_unit: PASSED **");
        end
        else
        begin
            $display("** echoing_line_editor_command_match_unit: FAILED **");
        end
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("** echoing_line_editor_command_match_unit: FAILED **");
        $finish;
    end

endmodule
